/* src/ffa_pkg.sv */
// Shared types, constants and codes of the first-fit arena allocator.
`timescale 1ns / 1ps

package ffa_pkg;

   localparam int ARENA_WORDS = 32768;
   localparam int WORD_W      = $clog2(ARENA_WORDS);
   localparam int LIMIT_W     = WORD_W + 1;
   localparam int LARGE_W     = WORD_W + 3;
   localparam int OUT_W       = 19;
   localparam int CSR_IDX_W   = 8;
   localparam int REQ_W       = 104;
   localparam int RSP_W       = 144;

   localparam logic [CSR_IDX_W-1:0] REG_START = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_END   = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      TAG_NONE = 2'd0,
      TAG_FREE = 2'd1,
      TAG_USED = 2'd2
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [WORD_W-1:0]   size;
   } entry_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_ZALLOC = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LATCH, DP_LAYOUT, DP_CLEAR, DP_HEAD, DP_MUL, DP_FAIL,
      DP_A_PREP, DP_A_RD, DP_A_CHK, DP_A_SPLIT, DP_A_MARK,
      DP_P_PREP, DP_P_RD, DP_P_EVAL, DP_KEEP, DP_F_MARK,
      DP_M_RD, DP_M_CHK, DP_N_RD, DP_N_CHK, DP_N_END,
      DP_S_INIT, DP_S_RD, DP_S_CHK, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       cfg_hit;
      logic       arena_ready;
      opcode_type op;
      logic       ptr_zero;
      logic       want_zero;
      logic       prod_ovf;
      logic       need_bad;
      logic       ptr_ok;
      logic       rd_used;
      logic       rd_free;
      logic       fit;
      logic       split;
      logic       fits;
      logic       walk_end;
      logic       nx_end;
      logic       clr_done;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LAYOUT, ST_CLEAR, ST_HEAD, ST_DISPATCH, ST_MUL, ST_MUL_CHK,
      ST_A_PREP, ST_A_RD, ST_A_CHK, ST_A_SPLIT, ST_A_MARK,
      ST_P_PREP, ST_P_RD, ST_P_CHK, ST_P_DEC, ST_F_MARK,
      ST_M_RD, ST_M_CHK, ST_N_RD, ST_N_CHK,
      ST_S_INIT, ST_S_RD, ST_S_CHK, ST_OUT
   } ctl_state_type;

endpackage

/* src/ffa_dpath.sv */
// Datapath of the allocator: header memory, walk pointers, arithmetic and result registers.
`timescale 1ns / 1ps

module ffa_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [ffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   input  logic [ffa_pkg::REQ_W-1:0]     req_tdata,
   input  ffa_pkg::dp_cmd_type           cmd,
   output ffa_pkg::dp_status_type        stat,
   output logic [ffa_pkg::RSP_W-1:0]     rsp_tdata
);

   localparam int WW = ffa_pkg::WORD_W;
   localparam int LW = ffa_pkg::LIMIT_W;
   localparam int GW = ffa_pkg::LARGE_W;
   localparam int OW = ffa_pkg::OUT_W;

   ffa_pkg::entry_type hdr_mem [ffa_pkg::ARENA_WORDS];
   ffa_pkg::entry_type rd_ff;

   logic               mem_rd;
   logic [WW-1:0]      mem_raddr;
   logic               mem_wr;
   logic [WW-1:0]      mem_waddr;
   ffa_pkg::entry_type mem_wdata;

   logic [31:0] start_ff, start_in, end_ff, end_in;
   logic [31:0] base_ff, base_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic ready_ff, ready_in;
   logic [31:0] fail_ff, fail_in;
   ffa_pkg::opcode_type op_ff, op_in;
   logic [31:0] want_ff, want_in, count_ff, count_in, ptr_ff, ptr_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] need_ff, need_in;
   logic need_bad_ff, need_bad_in, ptr_ok_ff, ptr_ok_in, fits_ff, fits_in;
   logic [WW-1:0] hdr_ff, hdr_in, hsize_ff, hsize_in;
   logic [WW-1:0] acc_ff, acc_in, newsize_ff, newsize_in;
   logic [LW-1:0] walk_ff, walk_in, nx_ff, nx_in, clr_ff, clr_in;
   logic [GW-1:0] copy_pend_ff, copy_pend_in, copy_ff, copy_in, largest_ff, largest_in;
   logic [31:0] addr_ff, addr_in;
   logic [OW-1:0] used_ff, used_in;
   logic [31:0] o_addr_ff, o_addr_in, o_fail_ff, o_fail_in;
   logic [OW-1:0] o_copy_ff, o_copy_in, o_used_ff, o_used_in;
   logic [OW-1:0] o_large_ff, o_large_in, o_total_ff, o_total_in;

   logic [WW-1:0] s;
   logic [28:0]   needw;
   logic          fit_c, split_c;
   logic [LW-1:0] walk_next;
   logic [31:0]   arg, argx, need_c;
   logic [31:0]   off;
   logic          ptr_ok_c;
   logic [31:0]   need_w;
   logic [GW-1:0] have_c;
   logic [31:0]   lo, hi, span;
   logic          no_arena;
   logic [LW-1:0] words_c;
   logic [WW-1:0] acc_new;

   always_comb begin
      s         = rd_ff.size;
      needw     = need_ff[31:3];
      fit_c     = (rd_ff.tag == ffa_pkg::TAG_FREE) && (29'(s) >= needw);
      split_c   = 30'(s) >= (30'(needw) + 30'd2);
      walk_next = walk_ff + LW'(1) + LW'(s);
      arg       = (op_ff == ffa_pkg::OP_ZALLOC) ? prod_ff[31:0] : want_ff;
      argx      = (arg == 32'd0) ? 32'd1 : arg;
      need_c    = (argx + 32'd7) & ~32'd7;
      off       = ptr_ff - base_ff;
      ptr_ok_c  = ready_ff && (ptr_ff > base_ff) && (off < 32'({limit_ff, 3'b000}))
                  && (off[2:0] == 3'd0);
      need_w    = (want_ff + 32'd7) & ~32'd7;
      have_c    = {s, 3'b000};
      lo        = (start_ff + 32'd7) & ~32'd7;
      hi        = end_ff & ~32'd7;
      span      = hi - lo;
      no_arena  = (hi <= lo) || (span <= 32'd8);
      words_c   = (span[31:3] > 29'(ffa_pkg::ARENA_WORDS)) ?
                  LW'(ffa_pkg::ARENA_WORDS) : LW'(span[31:3]);
      acc_new   = acc_ff + WW'(1) + s;
   end

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_valid && (csr_index == ffa_pkg::REG_START)) begin
         start_in = csr_data;
      end
      if (csr_valid && (csr_index == ffa_pkg::REG_END)) begin
         end_in = csr_data;
      end
      base_in = base_ff;   limit_in = limit_ff;   ready_in = ready_ff;
      fail_in = fail_ff;   op_in = op_ff;         want_in = want_ff;
      count_in = count_ff; ptr_in = ptr_ff;       prod_in = prod_ff;
      need_in = need_ff;   need_bad_in = need_bad_ff;
      ptr_ok_in = ptr_ok_ff; fits_in = fits_ff;   hdr_in = hdr_ff;
      hsize_in = hsize_ff; acc_in = acc_ff;       newsize_in = newsize_ff;
      walk_in = walk_ff;   nx_in = nx_ff;         clr_in = clr_ff;
      copy_pend_in = copy_pend_ff; copy_in = copy_ff; largest_in = largest_ff;
      addr_in = addr_ff;   used_in = used_ff;
      o_addr_in = o_addr_ff; o_fail_in = o_fail_ff; o_copy_in = o_copy_ff;
      o_used_in = o_used_ff; o_large_in = o_large_ff; o_total_in = o_total_ff;
      mem_rd    = 1'b0;
      mem_raddr = walk_ff[WW-1:0];
      mem_wr    = 1'b0;
      mem_waddr = walk_ff[WW-1:0];
      mem_wdata = '{tag: ffa_pkg::TAG_NONE, size: '0};

      unique case (cmd.op)
         ffa_pkg::DP_NOP: begin
         end
         ffa_pkg::DP_LATCH: begin
            op_in        = ffa_pkg::opcode_type'(req_tdata[1:0]);
            want_in      = req_tdata[33:2];
            count_in     = req_tdata[65:34];
            ptr_in       = req_tdata[97:66];
            addr_in      = 32'd0;
            copy_in      = '0;
            copy_pend_in = '0;
         end
         ffa_pkg::DP_LAYOUT: begin
            base_in  = no_arena ? 32'd0 : lo;
            limit_in = no_arena ? '0 : words_c;
            ready_in = !no_arena;
            fail_in  = 32'd0;
            clr_in   = LW'(1);
         end
         ffa_pkg::DP_CLEAR: begin
            mem_wr    = 1'b1;
            mem_waddr = clr_ff[WW-1:0];
            clr_in    = clr_ff + LW'(1);
         end
         ffa_pkg::DP_HEAD: begin
            mem_wr    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{tag: ffa_pkg::TAG_FREE, size: WW'(limit_ff - LW'(1))};
         end
         ffa_pkg::DP_MUL: begin
            prod_in = count_ff * want_ff;
         end
         ffa_pkg::DP_FAIL: begin
            fail_in = fail_ff + 32'd1;
         end
         ffa_pkg::DP_A_PREP: begin
            need_in     = need_c;
            need_bad_in = need_c < arg;
            walk_in     = '0;
         end
         ffa_pkg::DP_A_RD, ffa_pkg::DP_M_RD, ffa_pkg::DP_S_RD: begin
            mem_rd = 1'b1;
         end
         ffa_pkg::DP_A_CHK: begin
            if (fit_c) begin
               newsize_in = split_c ? needw[WW-1:0] : s;
            end else begin
               walk_in = walk_next;
            end
         end
         ffa_pkg::DP_A_SPLIT: begin
            // The remainder becomes a free block right after the granted payload.
            mem_wr    = 1'b1;
            mem_waddr = walk_ff[WW-1:0] + WW'(1) + needw[WW-1:0];
            mem_wdata = '{tag: ffa_pkg::TAG_FREE, size: s - needw[WW-1:0] - WW'(1)};
         end
         ffa_pkg::DP_A_MARK: begin
            mem_wr    = 1'b1;
            mem_wdata = '{tag: ffa_pkg::TAG_USED, size: newsize_ff};
            addr_in   = base_ff + 32'({walk_ff + LW'(1), 3'b000});
            copy_in   = copy_pend_ff;
         end
         ffa_pkg::DP_P_PREP: begin
            ptr_ok_in = ptr_ok_c;
            hdr_in    = WW'(off[31:3] - 29'd1);
         end
         ffa_pkg::DP_P_RD: begin
            mem_rd    = 1'b1;
            mem_raddr = hdr_ff;
         end
         ffa_pkg::DP_P_EVAL: begin
            hsize_in     = s;
            fits_in      = (need_w >= want_ff) && (32'(have_c) >= need_w);
            copy_pend_in = (32'(have_c) < want_ff) ? have_c : GW'(want_ff);
         end
         ffa_pkg::DP_KEEP: begin
            addr_in = ptr_ff;
         end
         ffa_pkg::DP_F_MARK: begin
            mem_wr    = 1'b1;
            mem_waddr = hdr_ff;
            mem_wdata = '{tag: ffa_pkg::TAG_FREE, size: hsize_ff};
            walk_in   = '0;
         end
         ffa_pkg::DP_M_CHK: begin
            if (rd_ff.tag == ffa_pkg::TAG_FREE) begin
               acc_in = s;
               nx_in  = walk_next;
            end else begin
               walk_in = walk_next;
            end
         end
         ffa_pkg::DP_N_RD: begin
            mem_rd    = 1'b1;
            mem_raddr = nx_ff[WW-1:0];
         end
         ffa_pkg::DP_N_CHK, ffa_pkg::DP_N_END: begin
            if ((cmd.op == ffa_pkg::DP_N_CHK) && (rd_ff.tag == ffa_pkg::TAG_FREE)) begin
               // Absorb the neighbor; its header word is retired.
               mem_wr    = 1'b1;
               mem_waddr = nx_ff[WW-1:0];
               mem_wdata = '{tag: ffa_pkg::TAG_NONE, size: s};
               acc_in    = acc_new;
               nx_in     = walk_ff + LW'(1) + LW'(acc_new);
            end else begin
               mem_wr    = 1'b1;
               mem_wdata = '{tag: ffa_pkg::TAG_FREE, size: acc_ff};
               walk_in   = nx_ff;
            end
         end
         ffa_pkg::DP_S_INIT: begin
            walk_in    = '0;
            used_in    = '0;
            largest_in = '0;
         end
         ffa_pkg::DP_S_CHK: begin
            if (rd_ff.tag == ffa_pkg::TAG_USED) begin
               used_in = used_ff + OW'({LW'(s) + LW'(1), 3'b000});
            end else if ((rd_ff.tag == ffa_pkg::TAG_FREE) && (have_c > largest_ff)) begin
               largest_in = have_c;
            end
            walk_in = walk_next;
         end
         ffa_pkg::DP_OUT: begin
            o_addr_in  = addr_ff;
            o_copy_in  = OW'(copy_ff);
            o_used_in  = used_ff;
            o_large_in = OW'(largest_ff);
            o_fail_in  = fail_ff;
            o_total_in = ready_ff ? OW'({limit_ff, 3'b000}) : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         hdr_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_ff <= hdr_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 32'd0;
         end_ff   <= 32'd0;
         base_ff  <= 32'd0;
         limit_ff <= '0;
         ready_ff <= 1'b0;
         fail_ff  <= 32'd0;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         base_ff  <= base_in;
         limit_ff <= limit_in;
         ready_ff <= ready_in;
         fail_ff  <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;         want_ff <= want_in;     count_ff <= count_in;
      ptr_ff <= ptr_in;       prod_ff <= prod_in;     need_ff <= need_in;
      need_bad_ff <= need_bad_in; ptr_ok_ff <= ptr_ok_in; fits_ff <= fits_in;
      hdr_ff <= hdr_in;       hsize_ff <= hsize_in;   acc_ff <= acc_in;
      newsize_ff <= newsize_in; walk_ff <= walk_in;   nx_ff <= nx_in;
      clr_ff <= clr_in;       copy_pend_ff <= copy_pend_in; copy_ff <= copy_in;
      largest_ff <= largest_in; addr_ff <= addr_in;   used_ff <= used_in;
      o_addr_ff <= o_addr_in; o_fail_ff <= o_fail_in; o_copy_ff <= o_copy_in;
      o_used_ff <= o_used_in; o_large_ff <= o_large_in; o_total_ff <= o_total_in;
   end

   always_comb begin
      stat.cfg_hit     = csr_valid && ((csr_index == ffa_pkg::REG_START) ||
                                       (csr_index == ffa_pkg::REG_END));
      stat.arena_ready = ready_ff;
      stat.op          = op_ff;
      stat.ptr_zero    = ptr_ff == 32'd0;
      stat.want_zero   = want_ff == 32'd0;
      stat.prod_ovf    = prod_ff[63:32] != 32'd0;
      stat.need_bad    = need_bad_ff;
      stat.ptr_ok      = ptr_ok_ff;
      stat.rd_used     = rd_ff.tag == ffa_pkg::TAG_USED;
      stat.rd_free     = rd_ff.tag == ffa_pkg::TAG_FREE;
      stat.fit         = fit_c;
      stat.split       = split_c;
      stat.fits        = fits_ff;
      stat.walk_end    = walk_ff >= limit_ff;
      stat.nx_end      = nx_ff >= limit_ff;
      stat.clr_done    = clr_ff >= limit_ff;
   end

   assign rsp_tdata = {4'b0000, o_total_ff, o_fail_ff, o_large_ff, o_used_ff,
                       o_copy_ff, o_addr_ff};

endmodule

/* src/ffa_ctrl.sv */
// Controller state machine of the allocator: sequences every walk over the block headers.
`timescale 1ns / 1ps

module ffa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ffa_pkg::dp_status_type stat,
   output ffa_pkg::dp_cmd_type    cmd
);

   ffa_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic reloc_ff, reloc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         reloc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reloc_ff     <= reloc_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      reloc_in     = reloc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = ffa_pkg::DP_NOP;
      req_tready   = (state_ff == ffa_pkg::ST_IDLE) && !stat.cfg_hit;

      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.op   = ffa_pkg::DP_LATCH;
               state_in = ffa_pkg::ST_DISPATCH;
            end
         end
         ffa_pkg::ST_LAYOUT: begin
            cmd.op   = ffa_pkg::DP_LAYOUT;
            state_in = ffa_pkg::ST_CLEAR;
         end
         ffa_pkg::ST_CLEAR: begin
            if (!stat.arena_ready) begin
               state_in = ffa_pkg::ST_IDLE;
            end else if (stat.clr_done) begin
               state_in = ffa_pkg::ST_HEAD;
            end else begin
               cmd.op = ffa_pkg::DP_CLEAR;
            end
         end
         ffa_pkg::ST_HEAD: begin
            cmd.op   = ffa_pkg::DP_HEAD;
            state_in = ffa_pkg::ST_IDLE;
         end
         ffa_pkg::ST_DISPATCH: begin
            reloc_in = 1'b0;
            case (stat.op)
               ffa_pkg::OP_ALLOC:  state_in = ffa_pkg::ST_A_PREP;
               ffa_pkg::OP_ZALLOC: state_in = ffa_pkg::ST_MUL;
               ffa_pkg::OP_FREE:
                  state_in = stat.ptr_zero ? ffa_pkg::ST_S_INIT : ffa_pkg::ST_P_PREP;
               default:
                  state_in = stat.ptr_zero ? ffa_pkg::ST_A_PREP : ffa_pkg::ST_P_PREP;
            endcase
         end
         ffa_pkg::ST_MUL: begin
            cmd.op   = ffa_pkg::DP_MUL;
            state_in = ffa_pkg::ST_MUL_CHK;
         end
         ffa_pkg::ST_MUL_CHK: begin
            if (stat.prod_ovf) begin
               cmd.op   = ffa_pkg::DP_FAIL;
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               state_in = ffa_pkg::ST_A_PREP;
            end
         end
         ffa_pkg::ST_A_PREP: begin
            cmd.op   = ffa_pkg::DP_A_PREP;
            state_in = ffa_pkg::ST_A_RD;
         end
         ffa_pkg::ST_A_RD: begin
            if (!stat.arena_ready || stat.need_bad || stat.walk_end) begin
               cmd.op   = ffa_pkg::DP_FAIL;
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               cmd.op   = ffa_pkg::DP_A_RD;
               state_in = ffa_pkg::ST_A_CHK;
            end
         end
         ffa_pkg::ST_A_CHK: begin
            cmd.op = ffa_pkg::DP_A_CHK;
            if (stat.fit) begin
               state_in = stat.split ? ffa_pkg::ST_A_SPLIT : ffa_pkg::ST_A_MARK;
            end else begin
               state_in = ffa_pkg::ST_A_RD;
            end
         end
         ffa_pkg::ST_A_SPLIT: begin
            cmd.op   = ffa_pkg::DP_A_SPLIT;
            state_in = ffa_pkg::ST_A_MARK;
         end
         ffa_pkg::ST_A_MARK: begin
            cmd.op   = ffa_pkg::DP_A_MARK;
            state_in = reloc_ff ? ffa_pkg::ST_F_MARK : ffa_pkg::ST_S_INIT;
         end
         ffa_pkg::ST_P_PREP: begin
            cmd.op   = ffa_pkg::DP_P_PREP;
            state_in = ffa_pkg::ST_P_RD;
         end
         ffa_pkg::ST_P_RD: begin
            if (!stat.ptr_ok) begin
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               cmd.op   = ffa_pkg::DP_P_RD;
               state_in = ffa_pkg::ST_P_CHK;
            end
         end
         ffa_pkg::ST_P_CHK: begin
            if (!stat.rd_used) begin
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               cmd.op = ffa_pkg::DP_P_EVAL;
               if ((stat.op == ffa_pkg::OP_FREE) || stat.want_zero) begin
                  state_in = ffa_pkg::ST_F_MARK;
               end else begin
                  state_in = ffa_pkg::ST_P_DEC;
               end
            end
         end
         ffa_pkg::ST_P_DEC: begin
            if (stat.fits) begin
               cmd.op   = ffa_pkg::DP_KEEP;
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               // Relocation: allocate first, release the old block only on success.
               reloc_in = 1'b1;
               state_in = ffa_pkg::ST_A_PREP;
            end
         end
         ffa_pkg::ST_F_MARK: begin
            cmd.op   = ffa_pkg::DP_F_MARK;
            state_in = ffa_pkg::ST_M_RD;
         end
         ffa_pkg::ST_M_RD: begin
            if (stat.walk_end) begin
               state_in = ffa_pkg::ST_S_INIT;
            end else begin
               cmd.op   = ffa_pkg::DP_M_RD;
               state_in = ffa_pkg::ST_M_CHK;
            end
         end
         ffa_pkg::ST_M_CHK: begin
            cmd.op   = ffa_pkg::DP_M_CHK;
            state_in = stat.rd_free ? ffa_pkg::ST_N_RD : ffa_pkg::ST_M_RD;
         end
         ffa_pkg::ST_N_RD: begin
            if (stat.nx_end) begin
               cmd.op   = ffa_pkg::DP_N_END;
               state_in = ffa_pkg::ST_M_RD;
            end else begin
               cmd.op   = ffa_pkg::DP_N_RD;
               state_in = ffa_pkg::ST_N_CHK;
            end
         end
         ffa_pkg::ST_N_CHK: begin
            cmd.op   = ffa_pkg::DP_N_CHK;
            state_in = stat.rd_free ? ffa_pkg::ST_N_RD : ffa_pkg::ST_M_RD;
         end
         ffa_pkg::ST_S_INIT: begin
            cmd.op   = ffa_pkg::DP_S_INIT;
            state_in = ffa_pkg::ST_S_RD;
         end
         ffa_pkg::ST_S_RD: begin
            if (!stat.arena_ready || stat.walk_end) begin
               state_in = ffa_pkg::ST_OUT;
            end else begin
               cmd.op   = ffa_pkg::DP_S_RD;
               state_in = ffa_pkg::ST_S_CHK;
            end
         end
         ffa_pkg::ST_S_CHK: begin
            cmd.op   = ffa_pkg::DP_S_CHK;
            state_in = ffa_pkg::ST_S_RD;
         end
         ffa_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = ffa_pkg::DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::ST_IDLE;
         end
      endcase

      // A register write relays the arena out again from scratch.
      if (stat.cfg_hit) begin
         cmd.op   = ffa_pkg::DP_NOP;
         reloc_in = 1'b0;
         state_in = ffa_pkg::ST_LAYOUT;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* src/first_fit_arena_allocator.sv */
// Each request makes up to three header walks (first-fit search, merge after a free,
// statistics); a merge may read a header twice.
// Throughput: one request at a time; the next transfer is taken while a result waits.
// Reset clears control state and the arena and failure registers, not the header memory;
// there is no arena until a register is written. Each register write that yields an arena
// runs a tag clearing pass over its words, requests held off.
`timescale 1ns / 1ps

module first_fit_arena_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode[1:0], want_bytes[33:2], element_count[65:34], pointer[97:66], zero fill
   input  logic [ffa_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // result_address[31:0], copy_bytes[50:32], used_bytes[69:51],
   // largest_free_bytes[88:70], failures_seen[120:89], arena_bytes_total[139:121], zero fill
   output logic [ffa_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   ffa_pkg::dp_cmd_type    cmd;
   ffa_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   ffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_used_fits : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[69:51]} + {1'b0, rsp_tdata[88:70]})
                     <= {1'b0, rsp_tdata[139:121]})
      else $error("used plus largest free exceeds arena size");

   a_copy_has_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[50:32] != 19'd0)) |-> (rsp_tdata[31:0] != 32'd0))
      else $error("copy reported without a granted address");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the first-fit arena allocator, with its own allocator predictor.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [31:0] address;
      logic [18:0] copy_bytes;
      logic [18:0] used_bytes;
      logic [18:0] largest_free;
      logic [31:0] failures;
      logic [18:0] arena_total;
   } grant_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ffa_pkg::REQ_W-1:0]     req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [ffa_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ffa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_data = '0;

   // Predictor state: a private copy of the header store and counters.
   ffa_pkg::tag_type hdr_tag[ffa_pkg::ARENA_WORDS];
   int unsigned      hdr_words[ffa_pkg::ARENA_WORDS];
   logic [31:0] reg_start, reg_end;
   logic [31:0] fail_count, base_addr;
   int unsigned limit_words;
   bit          have_arena;

   grant_type   grants_due[$];
   logic [31:0] live_ptrs[$];
   int          errors = 0;
   bit          calm = 1'b0;
   int          rx_hold = 0;

   first_fit_arena_allocator dut (.*);

   always #1 clock = ~clock;

   function automatic int unsigned next_hdr(int unsigned w);
      return w + 1 + hdr_words[w];
   endfunction

   function automatic void lay_out_arena();
      logic [31:0] lo, hi;
      lo = (reg_start + 32'd7) & ~32'd7;
      hi = reg_end & ~32'd7;
      foreach (hdr_tag[i]) hdr_tag[i] = ffa_pkg::TAG_NONE;
      fail_count = 0;
      base_addr = 0;
      limit_words = 0;
      have_arena = 1'b0;
      if (hi <= lo || hi - lo <= 32'd8) return;
      limit_words = (hi - lo) >> 3;
      if (limit_words > ffa_pkg::ARENA_WORDS) limit_words = ffa_pkg::ARENA_WORDS;
      base_addr = lo;
      have_arena = 1'b1;
      hdr_tag[0] = ffa_pkg::TAG_FREE;
      hdr_words[0] = limit_words - 1;
   endfunction

   function automatic void coalesce();
      int unsigned w, nx;
      w = 0;
      while (w < limit_words) begin
         if (hdr_tag[w] == ffa_pkg::TAG_FREE) begin
            nx = next_hdr(w);
            while (nx < limit_words && hdr_tag[nx] == ffa_pkg::TAG_FREE) begin
               hdr_words[w] += 1 + hdr_words[nx];
               hdr_tag[nx] = ffa_pkg::TAG_NONE;
               nx = next_hdr(w);
            end
         end
         w = next_hdr(w);
      end
   endfunction

   function automatic logic [31:0] first_fit(logic [31:0] want);
      logic [31:0] need;
      int unsigned needw, w, s, r;
      if (!have_arena) begin
         fail_count++;
         return 0;
      end
      need = ((want == 0 ? 32'd1 : want) + 32'd7) & ~32'd7;
      if (need < want) begin
         fail_count++;
         return 0;
      end
      needw = need >> 3;
      for (w = 0; w < limit_words; w = next_hdr(w)) begin
         s = hdr_words[w];
         if (hdr_tag[w] != ffa_pkg::TAG_FREE || s < needw) continue;
         if (s >= needw + 2) begin
            r = w + 1 + needw;
            hdr_tag[r] = ffa_pkg::TAG_FREE;
            hdr_words[r] = s - needw - 1;
            hdr_words[w] = needw;
         end
         hdr_tag[w] = ffa_pkg::TAG_USED;
         return base_addr + ((w + 1) << 3);
      end
      fail_count++;
      return 0;
   endfunction

   // Header index of a pointer to a used block, or -1.
   function automatic int used_header(logic [31:0] p);
      longint unsigned stop;
      logic [31:0] off;
      int unsigned w;
      stop = longint'(base_addr) + (longint'(limit_words) << 3);
      if (!have_arena || p <= base_addr || longint'(p) >= stop) return -1;
      off = p - base_addr;
      if (off[2:0] != 0) return -1;
      w = (off >> 3) - 1;
      if (w >= limit_words || hdr_tag[w] != ffa_pkg::TAG_USED) return -1;
      return w;
   endfunction

   function automatic void release_block(logic [31:0] p);
      int h;
      if (p == 0) return;
      h = used_header(p);
      if (h < 0) return;
      hdr_tag[h] = ffa_pkg::TAG_FREE;
      coalesce();
   endfunction

   function automatic grant_type predict_grant(ffa_pkg::opcode_type op, logic [31:0] want,
                                               logic [31:0] count, logic [31:0] p);
      grant_type g;
      logic [31:0] addr, copy, used, largest, have, need;
      logic [63:0] prod;
      int h;
      int unsigned w, s;
      addr = 0; copy = 0; used = 0; largest = 0;
      case (op)
         ffa_pkg::OP_ALLOC: addr = first_fit(want);
         ffa_pkg::OP_FREE: release_block(p);
         ffa_pkg::OP_RESIZE: begin
            if (p == 0) addr = first_fit(want);
            else if (want == 0) release_block(p);
            else begin
               h = used_header(p);
               if (h >= 0) begin
                  have = hdr_words[h] << 3;
                  need = (want + 32'd7) & ~32'd7;
                  if (need >= want && have >= need) addr = p;
                  else begin
                     addr = first_fit(want);
                     if (addr != 0) begin
                        copy = have < want ? have : want;
                        release_block(p);
                     end
                  end
               end
            end
         end
         default: begin
            prod = 64'(count) * 64'(want);
            if (prod > 64'hFFFF_FFFF) fail_count++;
            else addr = first_fit(prod[31:0]);
         end
      endcase
      for (w = 0; have_arena && w < limit_words; w = next_hdr(w)) begin
         s = hdr_words[w];
         if (hdr_tag[w] == ffa_pkg::TAG_USED) used += (1 + s) << 3;
         else if (hdr_tag[w] == ffa_pkg::TAG_FREE && (s << 3) > largest) largest = s << 3;
      end
      g.address = addr;
      g.copy_bytes = copy[18:0];
      g.used_bytes = used[18:0];
      g.largest_free = largest[18:0];
      g.failures = fail_count;
      g.arena_total = have_arena ? 19'(limit_words << 3) : 19'd0;
      return g;
   endfunction

   function automatic void drop_live(logic [31:0] p);
      foreach (live_ptrs[i])
         if (live_ptrs[i] == p) begin
            live_ptrs.delete(i);
            return;
         end
   endfunction

   task automatic send_request(ffa_pkg::opcode_type op, logic [31:0] want,
                               logic [31:0] count, logic [31:0] p);
      grant_type g;
      bit taken;
      if (!calm && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      g = predict_grant(op, want, count, p);
      grants_due.push_back(g);
      // Keep a list of blocks the client owns so frees and resizes hit real blocks.
      if (op == ffa_pkg::OP_FREE || (op == ffa_pkg::OP_RESIZE && p != 0 && want == 0))
         drop_live(p);
      else if (g.address != 0 && g.address != p) begin
         if (op == ffa_pkg::OP_RESIZE && p != 0) drop_live(p);
         live_ptrs.push_back(g.address);
      end
      req_tdata <= {6'd0, p, count, want, op};
      req_tvalid <= 1'b1;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [ffa_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      bit taken;
      drain();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      if (idx == ffa_pkg::REG_START) reg_start = value;
      else reg_end = value;
      lay_out_arena();
      live_ptrs.delete();
   endtask

   task automatic set_arena(logic [31:0] lo, logic [31:0] hi);
      write_reg(ffa_pkg::REG_START, lo);
      write_reg(ffa_pkg::REG_END, hi);
   endtask

   task automatic random_request();
      int pick;
      logic [31:0] p;
      pick = $urandom_range(0, 99);
      p = live_ptrs.size() != 0 ? live_ptrs[$urandom_range(0, live_ptrs.size() - 1)] : 32'd0;
      if (pick < 33) send_request(ffa_pkg::OP_ALLOC, $urandom_range(0, 72), $urandom, 0);
      else if (pick < 58) send_request(ffa_pkg::OP_FREE, $urandom, $urandom, p);
      else if (pick < 73) send_request(ffa_pkg::OP_RESIZE, $urandom_range(0, 96), $urandom, p);
      else if (pick < 83)
         send_request(ffa_pkg::OP_ZALLOC, $urandom_range(0, 16), $urandom_range(0, 8), p);
      else if (pick < 90)
         send_request(ffa_pkg::opcode_type'($urandom_range(0, 3)), $urandom, $urandom,
                      $urandom);
      else if (pick < 95)
         send_request(ffa_pkg::opcode_type'($urandom_range(1, 2)), $urandom_range(1, 40), 0,
                      p + 32'd4);
      else send_request(ffa_pkg::OP_ZALLOC, $urandom, $urandom, 0);
   endtask

   task automatic test_no_arena();
      send_request(ffa_pkg::OP_ALLOC, 5, 0, 0);
      send_request(ffa_pkg::OP_FREE, 0, 0, 32'h10);
      send_request(ffa_pkg::OP_RESIZE, 8, 0, 32'h10);
      send_request(ffa_pkg::OP_RESIZE, 8, 0, 0);
      send_request(ffa_pkg::OP_ZALLOC, 4, 4, 0);
      set_arena(32'h100, 32'h108);
      send_request(ffa_pkg::OP_ALLOC, 0, 0, 0);
   endtask

   task automatic test_special_cases();
      logic [31:0] a, b;
      set_arena(32'h1003, 32'h1400);
      send_request(ffa_pkg::OP_ALLOC, 0, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 32'hFFFF_FFF9, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 32'h0000_2000, 0, 0);
      send_request(ffa_pkg::OP_ZALLOC, 32'h0001_0000, 32'h0001_0000, 0);
      send_request(ffa_pkg::OP_ZALLOC, 32'hFFFF_FFFF, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 24, 0, 0);
      a = live_ptrs[$];
      send_request(ffa_pkg::OP_ALLOC, 40, 0, 0);
      b = live_ptrs[$];
      send_request(ffa_pkg::OP_FREE, 0, 0, 32'h1008);
      send_request(ffa_pkg::OP_FREE, 0, 0, a + 32'd3);
      send_request(ffa_pkg::OP_FREE, 0, 0, 32'h1400);
      send_request(ffa_pkg::OP_RESIZE, 16, 0, a);
      send_request(ffa_pkg::OP_RESIZE, 200, 0, a);
      send_request(ffa_pkg::OP_RESIZE, 32'h0000_4000, 0, b);
      send_request(ffa_pkg::OP_RESIZE, 32'hFFFF_FFFD, 0, b);
      send_request(ffa_pkg::OP_RESIZE, 8, 0, 32'h1010 + 32'd1);
      send_request(ffa_pkg::OP_RESIZE, 12, 0, 0);
      send_request(ffa_pkg::OP_RESIZE, 0, 0, b);
      send_request(ffa_pkg::OP_FREE, 0, 0, b);
      send_request(ffa_pkg::OP_FREE, 0, 0, 0);
   endtask

   task automatic test_arena_extremes();
      // A start that wraps when rounded up gives an arena of exactly two words.
      set_arena(32'hFFFF_FFF9, 32'h0000_0010);
      send_request(ffa_pkg::OP_ALLOC, 1, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 1, 0, 0);
      set_arena(32'h0, 32'hFFFF_FFFF);
      send_request(ffa_pkg::OP_ALLOC, 32'h0003_FF00, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 64, 0, 0);
      send_request(ffa_pkg::OP_FREE, 0, 0, live_ptrs[0]);
      set_arena(32'hFFFF_F000, 32'hFFFF_FFFF);
      send_request(ffa_pkg::OP_ALLOC, 100, 0, 0);
      send_request(ffa_pkg::OP_RESIZE, 300, 0, live_ptrs[0]);
      set_arena(32'h0, 32'h0);
      send_request(ffa_pkg::OP_ALLOC, 1, 0, 0);
   endtask

   task automatic test_random_traffic();
      logic [31:0] lo;
      for (int ph = 0; ph < 6; ph++) begin
         lo = (ph == 5) ? 32'hFFFF_FC00 - $urandom_range(0, 64) : $urandom;
         lo = lo > 32'hFFFF_F000 ? 32'hFFFF_F000 - $urandom_range(0, 64) : lo;
         set_arena(lo, lo + $urandom_range(256, 1280));
         calm = (ph == 2);
         for (int n = 0; n < 195; n++) begin
            if (ph == 3 && n == 60) begin
               @(negedge clock);
               rx_hold = 3000;
               @(posedge clock);
            end
            if (ph == 4 && n == 100) drain();
            random_request();
         end
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 21;
      end
   end

   task automatic compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $realtime, field, want, got);
      end
   endtask

   // Values are stable at the falling edge; a transfer seen here completes at the next rise.
   always @(negedge clock) begin
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            errors++;
            $display("%0t: result transfer with nothing expected, got %0h", $realtime,
                     rsp_tdata);
         end else begin
            g = grants_due.pop_front();
            compare("result_address", g.address, rsp_tdata[31:0]);
            compare("copy_bytes", 32'(g.copy_bytes), 32'(rsp_tdata[50:32]));
            compare("used_bytes", 32'(g.used_bytes), 32'(rsp_tdata[69:51]));
            compare("largest_free_bytes", 32'(g.largest_free), 32'(rsp_tdata[88:70]));
            compare("failures_seen", g.failures, rsp_tdata[120:89]);
            compare("arena_bytes_total", 32'(g.arena_total), 32'(rsp_tdata[139:121]));
         end
      end
   end

   initial begin
      reg_start = 0;
      reg_end = 0;
      lay_out_arena();
      foreach (hdr_words[i]) hdr_words[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_arena();
      test_special_cases();
      test_arena_extremes();
      test_random_traffic();
      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
src/ffa_pkg.sv
src/ffa_dpath.sv
src/ffa_ctrl.sv
src/first_fit_arena_allocator.sv
tb/sv/testbench.sv
